// ===== rtl/lzp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzp_pkg
// Types, codes and constants shared by the LZ token bitstream packer.
// ----------------------------------------------------------------------------
package lzp_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned LEN_BITS_DEF  = 16;
  localparam int unsigned CMD_DEPTH_DEF = 2;
  localparam int unsigned RES_DEPTH_DEF = 16;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFF_W     = 15;
  localparam int unsigned HI_W      = 9;
  localparam int unsigned LOW_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] FLAG_MSB   = 8'h80;
  localparam logic [HI_W-1:0]   END_GAMMA  = 9'd256;
  localparam logic [OFF_W-1:0]  OFF_RESET  = 15'd1;

  typedef enum logic [1:0] {
    REQ_LIT_RUN  = 2'd0,
    REQ_LIT_BYTE = 2'd1,
    REQ_MATCH    = 2'd2,
    REQ_END      = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_MATCH_FIRST = 2'd1,
    STATUS_OVERFLOW    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASSIC_MODE   = 2'd0,
    CFG_BACKWARDS_MODE = 2'd1
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FLAG,
    ST_GAMMA,
    ST_PEND,
    ST_LIT,
    ST_FLUSH,
    ST_DONE,
    ST_ERR
  } back_state_e;

  typedef struct packed {
    logic classic;
    logic backwards;
  } cfg_t;

  typedef struct packed {
    logic wr;
    logic commit;
    logic drop;
  } res_ctl_t;

  function automatic int unsigned gamma_w(int unsigned len_bits);
    return (len_bits > HI_W) ? len_bits : HI_W;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lzp_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzp_cmd_fifo
// Short word queue between the classifying front and the bit sequencer.
// ----------------------------------------------------------------------------
module lzp_cmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lzp_pkg::CMD_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = IW + 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [PW-1:0]    fill;

  assign fill    = wptr_q - rptr_q;
  assign full_o  = (fill == PW'(DEPTH));
  assign empty_o = (wptr_q == rptr_q);
  assign rdata_o = mem_q[rptr_q[IW-1:0]];

  always_comb begin
    wptr_d = wptr_q + PW'(wr_i && !full_o);
    rptr_d = rptr_q + PW'(rd_i && !empty_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wptr_q[IW-1:0]] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lzp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzp_front
// Accepts tokens and prepares gamma values and their code lengths.
// ----------------------------------------------------------------------------
module lzp_front #(
  parameter int unsigned LEN_BITS = lzp_pkg::LEN_BITS_DEF,
  localparam int unsigned GV_W    = lzp_pkg::gamma_w(LEN_BITS),
  localparam int unsigned IDX_W   = $clog2(GV_W)
) (
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [1:0]           req_type_i,
  input  wire logic [LEN_BITS-1:0]  run_length_i,
  input  wire logic [14:0]          match_offset_i,
  input  wire logic [7:0]           literal_byte_i,
  input  wire logic                 cmd_full_i,
  output logic                      cmd_wr_o,
  output logic [1:0]                cmd_kind_o,
  output logic [7:0]                cmd_lit_o,
  output logic [14:0]               cmd_off_o,
  output logic [6:0]                cmd_low_o,
  output logic [LEN_BITS-1:0]       cmd_len_o,
  output logic [IDX_W-1:0]          cmd_len_lead_o,
  output logic [LEN_BITS-1:0]       cmd_lenm1_o,
  output logic [IDX_W-1:0]          cmd_lenm1_lead_o,
  output logic [8:0]                cmd_hi_o,
  output logic [IDX_W-1:0]          cmd_hi_lead_o
);
  import lzp_pkg::*;

  function automatic logic [IDX_W-1:0] lead_pos(input logic [GV_W-1:0] v);
    logic [IDX_W-1:0] p;
    p = '0;
    for (int i = 0; i < GV_W; i++) begin
      if (v[i]) p = IDX_W'(i);
    end
    return p;
  endfunction

  req_type_e          kind;
  logic [OFF_W-1:0]   om1;
  logic [HI_W-1:0]    hi;
  logic [LEN_BITS-1:0] lenm1;

  always_comb begin
    kind  = req_type_e'(req_type_i);
    om1   = match_offset_i - OFF_W'(1);
    lenm1 = (run_length_i == '0) ? '0 : run_length_i - LEN_BITS'(1);
    hi    = (kind == REQ_END) ? END_GAMMA : ({1'b0, om1[OFF_W-1:LOW_W]} + HI_W'(1));
  end

  assign full             = cmd_full_i;
  assign cmd_wr_o         = push && !cmd_full_i;
  assign cmd_kind_o       = req_type_i;
  assign cmd_lit_o        = literal_byte_i;
  assign cmd_off_o        = match_offset_i;
  assign cmd_low_o        = om1[LOW_W-1:0];
  assign cmd_len_o        = run_length_i;
  assign cmd_len_lead_o   = lead_pos(GV_W'(run_length_i));
  assign cmd_lenm1_o      = lenm1;
  assign cmd_lenm1_lead_o = lead_pos(GV_W'(lenm1));
  assign cmd_hi_o         = hi;
  assign cmd_hi_lead_o    = lead_pos(GV_W'(hi));

endmodule
`default_nettype wire

// ===== rtl/lzp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzp_back
// Bit sequencer: emits flag bits one per cycle while the result queue is not
// full, packs flag bytes and the offset byte, and stages byte writes into the
// result queue.
module lzp_back #(
  parameter int unsigned ADDR_BITS = lzp_pkg::ADDR_BITS_DEF,
  parameter int unsigned LEN_BITS  = lzp_pkg::LEN_BITS_DEF,
  localparam int unsigned GV_W     = lzp_pkg::gamma_w(LEN_BITS),
  localparam int unsigned IDX_W    = $clog2(GV_W)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lzp_pkg::cfg_t        cfg_i,
  input  wire logic                 cmd_valid_i,
  output logic                      cmd_pop_o,
  input  wire logic [1:0]           cmd_kind_i,
  input  wire logic [7:0]           cmd_lit_i,
  input  wire logic [14:0]          cmd_off_i,
  input  wire logic [6:0]           cmd_low_i,
  input  wire logic [LEN_BITS-1:0]  cmd_len_i,
  input  wire logic [IDX_W-1:0]     cmd_len_lead_i,
  input  wire logic [LEN_BITS-1:0]  cmd_lenm1_i,
  input  wire logic [IDX_W-1:0]     cmd_lenm1_lead_i,
  input  wire logic [8:0]           cmd_hi_i,
  input  wire logic [IDX_W-1:0]     cmd_hi_lead_i,
  input  wire logic                 res_full_i,
  output lzp_pkg::res_ctl_t         res_ctl_o,
  output logic [ADDR_BITS-1:0]      res_addr_o,
  output logic [7:0]                res_data_o,
  output logic                      res_last_o,
  output lzp_pkg::status_e          res_status_o
);
  import lzp_pkg::*;

  localparam int unsigned PW = ADDR_BITS + 1;

  back_state_e state_q, state_d;

  req_type_e           kind_q, kind_d;
  logic [BYTE_W-1:0]   lit_q, lit_d;
  logic [OFF_W-1:0]    off_q, off_d;
  logic [LOW_W-1:0]    low_q, low_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic [IDX_W-1:0]    len_lead_q, len_lead_d;
  logic [LEN_BITS-1:0] lenm1_q, lenm1_d;
  logic [IDX_W-1:0]    lenm1_lead_q, lenm1_lead_d;
  logic [HI_W-1:0]     hi_q, hi_d;
  logic [IDX_W-1:0]    hi_lead_q, hi_lead_d;
  logic                new_match_q, new_match_d;

  logic [GV_W-1:0]     g_val_q, g_val_d;
  logic [IDX_W-1:0]    g_cnt_q, g_cnt_d;
  logic [IDX_W-1:0]    g_idx;
  logic                g_phase_q, g_phase_d;
  logic                g_inv_q, g_inv_d;
  logic                g_second_q, g_second_d;

  logic [PW-1:0]        pos_q, pos_d;
  logic [ADDR_BITS-1:0] faddr_q, faddr_d;
  logic [BYTE_W-1:0]    fval_q, fval_d;
  logic [BYTE_W-1:0]    fmask_q, fmask_d;
  logic                 drop_q, drop_d;
  logic [OFF_W-1:0]     prev_q, prev_d;

  logic [PW-1:0]        s_pos_q, s_pos_d;
  logic [ADDR_BITS-1:0] s_faddr_q, s_faddr_d;
  logic [BYTE_W-1:0]    s_fval_q, s_fval_d;
  logic [BYTE_W-1:0]    s_fmask_q, s_fmask_d;
  logic                 s_drop_q, s_drop_d;
  logic [OFF_W-1:0]     s_prev_q, s_prev_d;

  logic                 pend_q, pend_d;
  logic [ADDR_BITS-1:0] pend_addr_q, pend_addr_d;
  logic [BYTE_W-1:0]    pend_val_q, pend_val_d;
  logic                 ovf_q, ovf_d;

  logic                 held_valid_q, held_valid_d;
  logic [ADDR_BITS-1:0] held_addr_q, held_addr_d;
  logic [BYTE_W-1:0]    held_data_q, held_data_d;

  logic                 adv, bw, inv_cfg;
  logic                 bit_en, bit_v;
  logic                 emit;
  logic [ADDR_BITS-1:0] emit_addr;
  logic [BYTE_W-1:0]    emit_data;
  logic                 open_byte;
  logic [BYTE_W-1:0]    cur_mask;
  logic [BYTE_W-1:0]    cur_val;

  assign adv     = !res_full_i;
  assign bw      = cfg_i.backwards;
  assign inv_cfg = !cfg_i.classic && !cfg_i.backwards;
  assign g_idx   = g_cnt_q - IDX_W'(1);

  always_comb begin
    bit_en = 1'b0;
    bit_v  = 1'b0;
    case (state_q)
      ST_FLAG: begin
        bit_en = 1'b1;
        bit_v  = new_match_q || (kind_q == REQ_END);
      end
      ST_GAMMA: begin
        bit_en = 1'b1;
        if (g_cnt_q != '0) begin
          bit_v = g_phase_q ? (g_val_q[g_idx] ^ g_inv_q) : bw;
        end else begin
          bit_v = !bw;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    if (adv) begin
      case (state_q)
        ST_IDLE:   if (cmd_valid_i) state_d = ST_DECODE;
        ST_DECODE: begin
          if ((kind_q == REQ_MATCH || kind_q == REQ_END) && drop_q) begin
            state_d = ST_ERR;
          end else if (kind_q == REQ_LIT_BYTE) begin
            state_d = ST_LIT;
          end else begin
            state_d = ST_FLAG;
          end
        end
        ST_FLAG:   state_d = ST_GAMMA;
        ST_GAMMA: begin
          if (g_cnt_q == '0) begin
            if (new_match_q && !g_second_q) begin
              state_d = ST_PEND;
            end else if (kind_q == REQ_END) begin
              state_d = ST_FLUSH;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
        ST_PEND:   state_d = ST_GAMMA;
        ST_LIT:    state_d = ST_DONE;
        ST_FLUSH:  state_d = ST_DONE;
        ST_DONE:   state_d = ST_IDLE;
        ST_ERR:    state_d = ST_IDLE;
        default:   state_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    kind_d       = kind_q;
    lit_d        = lit_q;
    off_d        = off_q;
    low_d        = low_q;
    len_d        = len_q;
    len_lead_d   = len_lead_q;
    lenm1_d      = lenm1_q;
    lenm1_lead_d = lenm1_lead_q;
    hi_d         = hi_q;
    hi_lead_d    = hi_lead_q;
    new_match_d  = new_match_q;
    g_val_d      = g_val_q;
    g_cnt_d      = g_cnt_q;
    g_phase_d    = g_phase_q;
    g_inv_d      = g_inv_q;
    g_second_d   = g_second_q;
    pos_d        = pos_q;
    faddr_d      = faddr_q;
    fval_d       = fval_q;
    fmask_d      = fmask_q;
    drop_d       = drop_q;
    prev_d       = prev_q;
    s_pos_d      = s_pos_q;
    s_faddr_d    = s_faddr_q;
    s_fval_d     = s_fval_q;
    s_fmask_d    = s_fmask_q;
    s_drop_d     = s_drop_q;
    s_prev_d     = s_prev_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    pend_val_d   = pend_val_q;
    ovf_d        = ovf_q;
    held_valid_d = held_valid_q;
    held_addr_d  = held_addr_q;
    held_data_d  = held_data_q;
    cmd_pop_o    = 1'b0;
    res_ctl_o    = '0;
    res_addr_o   = held_addr_q;
    res_data_o   = held_data_q;
    res_last_o   = 1'b0;
    res_status_o = STATUS_OK;
    emit         = 1'b0;
    emit_addr    = '0;
    emit_data    = '0;
    open_byte    = (fmask_q == '0);
    cur_mask     = open_byte ? FLAG_MSB : fmask_q;
    cur_val      = (open_byte ? '0 : fval_q) | (bit_v ? cur_mask : '0);

    if (adv) begin
      // put one flag bit
      if (bit_en) begin
        if (drop_q) begin
          drop_d = 1'b0;
          if (pend_q) begin
            emit      = 1'b1;
            emit_addr = pend_addr_q;
            emit_data = pend_val_q | BYTE_W'(bit_v);
            pend_d    = 1'b0;
          end
        end else begin
          if (open_byte) begin
            faddr_d = pos_q[ADDR_BITS-1:0];
            pos_d   = pos_q + PW'(1);
            ovf_d   = ovf_q || pos_q[ADDR_BITS];
          end
          fval_d  = cur_val;
          fmask_d = cur_mask >> 1;
          if (cur_mask[0]) begin
            emit      = 1'b1;
            emit_addr = open_byte ? pos_q[ADDR_BITS-1:0] : faddr_q;
            emit_data = cur_val;
          end
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_pop_o    = 1'b1;
            kind_d       = req_type_e'(cmd_kind_i);
            lit_d        = cmd_lit_i;
            off_d        = cmd_off_i;
            low_d        = cmd_low_i;
            len_d        = cmd_len_i;
            len_lead_d   = cmd_len_lead_i;
            lenm1_d      = cmd_lenm1_i;
            lenm1_lead_d = cmd_lenm1_lead_i;
            hi_d         = cmd_hi_i;
            hi_lead_d    = cmd_hi_lead_i;
          end
        end
        ST_DECODE: begin
          new_match_d = (kind_q == REQ_MATCH) && (off_q != prev_q);
          s_pos_d     = pos_q;
          s_faddr_d   = faddr_q;
          s_fval_d    = fval_q;
          s_fmask_d   = fmask_q;
          s_drop_d    = drop_q;
          s_prev_d    = prev_q;
          pend_d      = 1'b0;
          ovf_d       = 1'b0;
        end
        ST_FLAG: begin
          g_phase_d  = 1'b0;
          g_second_d = 1'b0;
          if (new_match_q || kind_q == REQ_END) begin
            g_val_d = GV_W'(hi_q);
            g_cnt_d = hi_lead_q;
            g_inv_d = inv_cfg;
          end else begin
            g_val_d = GV_W'(len_q);
            g_cnt_d = len_lead_q;
            g_inv_d = 1'b0;
          end
        end
        ST_GAMMA: begin
          if (g_cnt_q != '0) begin
            if (g_phase_q) begin
              g_cnt_d   = g_idx;
              g_phase_d = 1'b0;
            end else begin
              g_phase_d = 1'b1;
            end
          end
        end
        ST_PEND: begin
          pend_addr_d = pos_q[ADDR_BITS-1:0];
          pos_d       = pos_q + PW'(1);
          ovf_d       = ovf_q || pos_q[ADDR_BITS];
          pend_val_d  = {(bw ? low_q : ~low_q), 1'b0};
          pend_d      = 1'b1;
          drop_d      = 1'b1;
          prev_d      = off_q;
          g_val_d     = GV_W'(lenm1_q);
          g_cnt_d     = lenm1_lead_q;
          g_inv_d     = 1'b0;
          g_phase_d   = 1'b0;
          g_second_d  = 1'b1;
        end
        ST_LIT: begin
          pos_d     = pos_q + PW'(1);
          ovf_d     = ovf_q || pos_q[ADDR_BITS];
          emit      = 1'b1;
          emit_addr = pos_q[ADDR_BITS-1:0];
          emit_data = lit_q;
        end
        ST_FLUSH: begin
          if (fmask_q != '0) begin
            emit      = 1'b1;
            emit_addr = faddr_q;
            emit_data = fval_q;
          end
          pos_d   = '0;
          faddr_d = '0;
          fval_d  = '0;
          fmask_d = '0;
          drop_d  = 1'b1;
          prev_d  = OFF_RESET;
        end
        ST_DONE: begin
          held_valid_d = 1'b0;
          res_ctl_o.commit = 1'b1;
          if (ovf_q) begin
            // drop staged writes, restore state, report overflow
            res_ctl_o.wr   = 1'b1;
            res_ctl_o.drop = 1'b1;
            res_addr_o     = s_pos_q[ADDR_BITS-1:0];
            res_data_o     = '0;
            res_last_o     = 1'b1;
            res_status_o   = STATUS_OVERFLOW;
            pos_d          = s_pos_q;
            faddr_d        = s_faddr_q;
            fval_d         = s_fval_q;
            fmask_d        = s_fmask_q;
            drop_d         = s_drop_q;
            prev_d         = s_prev_q;
          end else if (held_valid_q) begin
            res_ctl_o.wr = 1'b1;
            res_last_o   = 1'b1;
          end
        end
        ST_ERR: begin
          res_ctl_o.wr     = 1'b1;
          res_ctl_o.commit = 1'b1;
          res_addr_o       = pos_q[ADDR_BITS-1:0];
          res_data_o       = '0;
          res_last_o       = 1'b1;
          res_status_o     = STATUS_MATCH_FIRST;
        end
        default: ;
      endcase

      // hold the newest write until the next one shows it is not the last
      if (emit) begin
        if (held_valid_q) begin
          res_ctl_o.wr = 1'b1;
        end
        held_valid_d = 1'b1;
        held_addr_d  = emit_addr;
        held_data_d  = emit_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      faddr_q      <= '0;
      fval_q       <= '0;
      fmask_q      <= '0;
      drop_q       <= 1'b1;
      prev_q       <= OFF_RESET;
      pend_q       <= 1'b0;
      ovf_q        <= 1'b0;
      held_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      faddr_q      <= faddr_d;
      fval_q       <= fval_d;
      fmask_q      <= fmask_d;
      drop_q       <= drop_d;
      prev_q       <= prev_d;
      pend_q       <= pend_d;
      ovf_q        <= ovf_d;
      held_valid_q <= held_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    lit_q        <= lit_d;
    off_q        <= off_d;
    low_q        <= low_d;
    len_q        <= len_d;
    len_lead_q   <= len_lead_d;
    lenm1_q      <= lenm1_d;
    lenm1_lead_q <= lenm1_lead_d;
    hi_q         <= hi_d;
    hi_lead_q    <= hi_lead_d;
    new_match_q  <= new_match_d;
    g_val_q      <= g_val_d;
    g_cnt_q      <= g_cnt_d;
    g_phase_q    <= g_phase_d;
    g_inv_q      <= g_inv_d;
    g_second_q   <= g_second_d;
    s_pos_q      <= s_pos_d;
    s_faddr_q    <= s_faddr_d;
    s_fval_q     <= s_fval_d;
    s_fmask_q    <= s_fmask_d;
    s_drop_q     <= s_drop_d;
    s_prev_q     <= s_prev_d;
    pend_addr_q  <= pend_addr_d;
    pend_val_q   <= pend_val_d;
    held_addr_q  <= held_addr_d;
    held_data_q  <= held_data_d;
  end

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ctl_o.wr |-> !res_full_i)
    else $error("result write while queue full");

  a_err_only_before_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERR) |-> drop_q)
    else $error("match-first error without open drop bit");

  a_offset_byte_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !ovf_q) |-> !pend_q)
    else $error("offset byte left unwritten at item end");

endmodule
`default_nettype wire

// ===== rtl/lzp_res_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzp_res_fifo
// Result queue with a commit point: words of a token become visible only
// once the token completes, and are discarded when it is rejected.
// ----------------------------------------------------------------------------
module lzp_res_fifo #(
  parameter int unsigned ADDR_BITS = lzp_pkg::ADDR_BITS_DEF,
  parameter int unsigned DEPTH     = lzp_pkg::RES_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lzp_pkg::res_ctl_t     ctl_i,
  input  wire logic [ADDR_BITS-1:0]  wr_addr_i,
  input  wire logic [7:0]            wr_data_i,
  input  wire logic                  wr_last_i,
  input  wire lzp_pkg::status_e      wr_status_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output logic [ADDR_BITS-1:0]       rd_addr_o,
  output logic [7:0]                 rd_data_o,
  output logic                       rd_last_o,
  output lzp_pkg::status_e           rd_status_o
);
  import lzp_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned PW = IW + 1;

  logic [ADDR_BITS-1:0] addr_q   [DEPTH];
  logic [BYTE_W-1:0]    data_q   [DEPTH];
  logic                 last_q   [DEPTH];
  status_e              status_q [DEPTH];

  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] cptr_q, cptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [PW-1:0] base;
  logic [PW-1:0] fill;
  logic [PW-1:0] ready_cnt;

  assign fill        = wptr_q - rptr_q;
  assign ready_cnt   = cptr_q - rptr_q;
  assign full_o      = (fill == PW'(DEPTH));
  assign empty_o     = (rptr_q == cptr_q);
  assign rd_addr_o   = addr_q[rptr_q[IW-1:0]];
  assign rd_data_o   = data_q[rptr_q[IW-1:0]];
  assign rd_last_o   = last_q[rptr_q[IW-1:0]];
  assign rd_status_o = status_q[rptr_q[IW-1:0]];

  always_comb begin
    base   = ctl_i.drop ? cptr_q : wptr_q;
    wptr_d = base + PW'(ctl_i.wr);
    cptr_d = ctl_i.commit ? wptr_d : cptr_q;
    rptr_d = rptr_q + PW'(pop_i && !empty_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      cptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      cptr_q <= cptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      addr_q[base[IW-1:0]]   <= wr_addr_i;
      data_q[base[IW-1:0]]   <= wr_data_i;
      last_q[base[IW-1:0]]   <= wr_last_i;
      status_q[base[IW-1:0]] <= wr_status_i;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= PW'(DEPTH))
    else $error("result queue over capacity");

  a_commit_behind_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_cnt <= fill)
    else $error("commit point ahead of write pointer");

  a_commit_shows_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.wr && ctl_i.commit) |=> !empty_o)
    else $error("committed word not visible");

endmodule
`default_nettype wire

// ===== rtl/lz_token_bitstream_packer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lz_token_bitstream_packer
// Packs LZ tokens into a compressed bitstream as byte writes.
//
// Input side is a queue: present a token and raise push; it is taken when
// full is low. Results come out of a queue: while empty is low the oldest
// byte write (write_addr_o, write_data_o, is_last_o, status_o) is shown,
// and pop takes it. Settings are written over the cfg channel (ready is
// always high); the user must do this while no token is in flight, unchecked.
// A token is worked off by the single-bit shift sequencer: a literal byte
// is written as one byte, a run header or repeat match takes a flag bit
// and the length gamma, a new-offset match its flag bit, the offset gamma,
// the offset byte and the gamma of length minus one, an end marker its
// flag bit, the end gamma and a flush. Words of a token appear once the
// token is finished; a rejected token shows a single status word instead.
// A two-entry token queue keeps push open while the sequencer works, and
// the sequencer holds when the 16-entry result queue is full.
// Reset empties both queues and starts a new stream at address 0.
// ----------------------------------------------------------------------------
module lz_token_bitstream_packer #(
  parameter int unsigned ADDR_BITS = lzp_pkg::ADDR_BITS_DEF,
  parameter int unsigned LEN_BITS  = lzp_pkg::LEN_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [LEN_BITS-1:0]           run_length_i,
  input  wire logic [14:0]                   match_offset_i,
  input  wire logic [7:0]                    literal_byte_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [ADDR_BITS-1:0]               write_addr_o,
  output logic [7:0]                         write_data_o,
  output logic                               is_last_o,
  output logic [1:0]                         status_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lzp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic                          cfg_data_i
);
  import lzp_pkg::*;

  localparam int unsigned GV_W  = gamma_w(LEN_BITS);
  localparam int unsigned IDX_W = $clog2(GV_W);
  localparam int unsigned CMD_W = 2 + BYTE_W + OFF_W + LOW_W + 2 * LEN_BITS
                                  + 3 * IDX_W + HI_W;

  cfg_t cfg_q;

  logic                cmd_wr, cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0]    cmd_wdata, cmd_rdata;
  logic [1:0]          f_kind, b_kind;
  logic [7:0]          f_lit, b_lit;
  logic [14:0]         f_off, b_off;
  logic [6:0]          f_low, b_low;
  logic [LEN_BITS-1:0] f_len, b_len, f_lenm1, b_lenm1;
  logic [IDX_W-1:0]    f_len_lead, b_len_lead, f_lenm1_lead, b_lenm1_lead;
  logic [IDX_W-1:0]    f_hi_lead, b_hi_lead;
  logic [8:0]          f_hi, b_hi;

  res_ctl_t             res_ctl;
  logic                 res_full;
  logic [ADDR_BITS-1:0] res_addr;
  logic [7:0]           res_data;
  logic                 res_last;
  status_e              res_status;
  status_e              rd_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CLASSIC_MODE:   cfg_q.classic   <= cfg_data_i;
        CFG_BACKWARDS_MODE: cfg_q.backwards <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lzp_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .push             (push),
    .full             (full),
    .req_type_i       (req_type_i),
    .run_length_i     (run_length_i),
    .match_offset_i   (match_offset_i),
    .literal_byte_i   (literal_byte_i),
    .cmd_full_i       (cmd_full),
    .cmd_wr_o         (cmd_wr),
    .cmd_kind_o       (f_kind),
    .cmd_lit_o        (f_lit),
    .cmd_off_o        (f_off),
    .cmd_low_o        (f_low),
    .cmd_len_o        (f_len),
    .cmd_len_lead_o   (f_len_lead),
    .cmd_lenm1_o      (f_lenm1),
    .cmd_lenm1_lead_o (f_lenm1_lead),
    .cmd_hi_o         (f_hi),
    .cmd_hi_lead_o    (f_hi_lead)
  );

  assign cmd_wdata = {f_kind, f_lit, f_off, f_low, f_len, f_len_lead,
                      f_lenm1, f_lenm1_lead, f_hi, f_hi_lead};
  assign {b_kind, b_lit, b_off, b_low, b_len, b_len_lead,
          b_lenm1, b_lenm1_lead, b_hi, b_hi_lead} = cmd_rdata;

  lzp_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH_DEF)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  lzp_back #(
    .ADDR_BITS (ADDR_BITS),
    .LEN_BITS  (LEN_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_valid_i      (!cmd_empty),
    .cmd_pop_o        (cmd_pop),
    .cmd_kind_i       (b_kind),
    .cmd_lit_i        (b_lit),
    .cmd_off_i        (b_off),
    .cmd_low_i        (b_low),
    .cmd_len_i        (b_len),
    .cmd_len_lead_i   (b_len_lead),
    .cmd_lenm1_i      (b_lenm1),
    .cmd_lenm1_lead_i (b_lenm1_lead),
    .cmd_hi_i         (b_hi),
    .cmd_hi_lead_i    (b_hi_lead),
    .res_full_i       (res_full),
    .res_ctl_o        (res_ctl),
    .res_addr_o       (res_addr),
    .res_data_o       (res_data),
    .res_last_o       (res_last),
    .res_status_o     (res_status)
  );

  lzp_res_fifo #(
    .ADDR_BITS (ADDR_BITS),
    .DEPTH     (RES_DEPTH_DEF)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (res_ctl),
    .wr_addr_i   (res_addr),
    .wr_data_i   (res_data),
    .wr_last_i   (res_last),
    .wr_status_i (res_status),
    .full_o      (res_full),
    .pop_i       (pop),
    .empty_o     (empty),
    .rd_addr_o   (write_addr_o),
    .rd_data_o   (write_data_o),
    .rd_last_o   (is_last_o),
    .rd_status_o (rd_status)
  );

  assign status_o = rd_status;

endmodule
`default_nettype wire
